@@ src/nst_pkg.sv @@
// Shared types and constants for the NAT session table.
// No dependencies; used by nst_cell and nat_session_table_lru.
package nst_pkg;

  localparam int unsigned KEY_W  = 96;
  localparam int unsigned PORT_W = 16;
  localparam logic [PORT_W-1:0] PORT_BASE = 16'd10000;

  localparam logic [1:0] OP_LOOKUP  = 2'd0;
  localparam logic [1:0] OP_ERASE   = 2'd1;
  localparam logic [1:0] OP_REVERSE = 2'd2;

  // broadcast commands to the row of cells
  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_MATCH_KEY,
    CMD_MATCH_PORT,
    CMD_MATCH_RANK,
    CMD_MATCH_FREE,
    CMD_PROMOTE,
    CMD_REMOVE,
    CMD_INSERT
  } cmd_e;

  typedef struct packed {
    cmd_e              op;
    logic [KEY_W-1:0]  key;
    logic [PORT_W-1:0] port;
  } cmd_t;

endpackage

@@ src/nst_cell.sv @@
// One session slot of the NAT table plus its stage of the result chain.
// Depends on nst_pkg.
module nst_cell #(
  parameter int unsigned RW       = 6,
  parameter int unsigned IW       = 6,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  nst_pkg::cmd_t             cmd_i,
  input  logic [RW-1:0]             cmd_rank_i,
  input  logic [IW-1:0]             cmd_idx_i,
  input  logic                      chain_found_i,
  input  logic [nst_pkg::KEY_W-1:0] chain_key_i,
  input  logic [nst_pkg::PORT_W-1:0] chain_port_i,
  input  logic [RW-1:0]             chain_rank_i,
  input  logic [IW-1:0]             chain_idx_i,
  output logic                      chain_found_o,
  output logic [nst_pkg::KEY_W-1:0] chain_key_o,
  output logic [nst_pkg::PORT_W-1:0] chain_port_o,
  output logic [RW-1:0]             chain_rank_o,
  output logic [IW-1:0]             chain_idx_o
);

  localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

  logic                       valid_q, valid_d;
  logic                       hit_q, hit_d;
  logic [nst_pkg::KEY_W-1:0]  key_q, key_d;
  logic [nst_pkg::PORT_W-1:0] port_q, port_d;
  logic [RW-1:0]              rank_q, rank_d;

  always_comb begin
    valid_d = valid_q;
    hit_d   = hit_q;
    key_d   = key_q;
    port_d  = port_q;
    rank_d  = rank_q;
    unique case (cmd_i.op)
      nst_pkg::CMD_MATCH_KEY:  hit_d = valid_q && (key_q == cmd_i.key);
      nst_pkg::CMD_MATCH_PORT: hit_d = valid_q && (port_q == cmd_i.port);
      nst_pkg::CMD_MATCH_RANK: hit_d = valid_q && (rank_q == cmd_rank_i);
      nst_pkg::CMD_MATCH_FREE: hit_d = !valid_q;
      nst_pkg::CMD_PROMOTE: begin
        if (hit_q) begin
          rank_d = '0;
        end else if (valid_q && rank_q < cmd_rank_i) begin
          rank_d = rank_q + 1'b1;
        end
      end
      nst_pkg::CMD_REMOVE: begin
        if (hit_q) begin
          valid_d = 1'b0;
        end else if (valid_q && rank_q > cmd_rank_i) begin
          rank_d = rank_q - 1'b1;
        end
      end
      nst_pkg::CMD_INSERT: begin
        if (cmd_idx_i == MY_IDX) begin
          valid_d = 1'b1;
          key_d   = cmd_i.key;
          port_d  = cmd_i.port;
          rank_d  = '0;
        end else if (valid_q) begin
          rank_d = rank_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= 1'b0;
      hit_q         <= 1'b0;
      chain_found_o <= 1'b0;
    end else begin
      valid_q       <= valid_d;
      hit_q         <= hit_d;
      chain_found_o <= hit_q | chain_found_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    port_q <= port_d;
    rank_q <= rank_d;
    if (hit_q) begin
      chain_key_o  <= key_q;
      chain_port_o <= port_q;
      chain_rank_o <= rank_q;
      chain_idx_o  <= MY_IDX;
    end else begin
      chain_key_o  <= chain_key_i;
      chain_port_o <= chain_port_i;
      chain_rank_o <= chain_rank_i;
      chain_idx_o  <= chain_idx_i;
    end
  end

endmodule

@@ src/nat_session_table_lru.sv @@
// NAT session table with least-recently-used eviction: top level and sequencer.
// Depends on nst_pkg and nst_cell.
//
// One word is taken when start is high and busy is low; each word gives one
// result, shown for a single cycle with result_valid_o high, which the
// receiver must take then. Every search broadcasts a compare to the row of
// TABLE_ENTRIES cells and then waits in S_WAIT while the matching slot walks
// the result chain to its end. Erase, reverse lookup and a lookup hit each
// need one search. A create needs the key search, an eviction search when the
// limit is reached, one search per port candidate probed and a free-slot
// search. Opcode three returns an all-zero result. The session cap register
// lies at byte address 0 and should be written only while busy is low.
module nat_session_table_lru #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] src_ip_i,
  input  logic [15:0] src_port_i,
  input  logic [31:0] dst_ip_i,
  input  logic [15:0] dst_port_i,
  input  logic [15:0] query_port_i,
  output logic        result_valid_o,
  output logic        found_o,
  output logic [15:0] mapped_port_o,
  output logic        evicted_valid_o,
  output logic [15:0] evicted_port_o,
  output logic [31:0] flow_src_ip_o,
  output logic [15:0] flow_src_port_o,
  output logic [31:0] flow_dst_ip_o,
  output logic [15:0] flow_dst_port_o
);

  localparam int unsigned N  = TABLE_ENTRIES;
  localparam int unsigned IW = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned RW = IW;
  localparam int unsigned LW = $clog2(N + 1);
  localparam int unsigned KW = nst_pkg::KEY_W;
  localparam int unsigned PW = nst_pkg::PORT_W;

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_WAIT       = 4'd1;
  localparam logic [3:0] S_KEY_DONE   = 4'd2;
  localparam logic [3:0] S_EVICT_DONE = 4'd3;
  localparam logic [3:0] S_PROBE      = 4'd4;
  localparam logic [3:0] S_PROBE_DONE = 4'd5;
  localparam logic [3:0] S_FREE_DONE  = 4'd6;
  localparam logic [3:0] S_PORT_DONE  = 4'd7;

  // ---------------------------------------------------------------- config
  logic [6:0] max_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr == 3'd0) ? {25'd0, max_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
    end else if (cfg_wr && paddr == 3'd0) begin
      max_q <= pwdata[6:0];
    end
  end

  // ---------------------------------------------------------------- state
  logic [3:0]    state_q, state_d, ret_q, ret_d;
  logic [LW-1:0] cnt_q, cnt_d;
  logic [LW-1:0] live_q, live_d;
  logic [PW-1:0] ctr_q, ctr_d;
  logic [PW-1:0] cand_q, cand_d;
  logic [1:0]    op_q, op_d;
  logic [KW-1:0] key_q, key_d;
  logic          ev_valid_q, ev_valid_d;
  logic [PW-1:0] ev_port_q, ev_port_d;

  // result word registers
  logic          res_v_d;
  logic          res_found_d;
  logic [PW-1:0] res_mport_d;
  logic          res_ev_d;
  logic [PW-1:0] res_evport_d;
  logic [KW-1:0] res_key_d;

  // broadcast to cells
  nst_pkg::cmd_t cmd;
  logic [RW-1:0] cmd_rank;
  logic [IW-1:0] cmd_idx;

  // result chain, position 0 feeds cell 0
  logic          ch_found [N+1];
  logic [KW-1:0] ch_key   [N+1];
  logic [PW-1:0] ch_port  [N+1];
  logic [RW-1:0] ch_rank  [N+1];
  logic [IW-1:0] ch_idx   [N+1];

  assign ch_found[0] = 1'b0;
  assign ch_key[0]   = '0;
  assign ch_port[0]  = '0;
  assign ch_rank[0]  = '0;
  assign ch_idx[0]   = '0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    nst_cell #(
      .RW       (RW),
      .IW       (IW),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .cmd_rank_i    (cmd_rank),
      .cmd_idx_i     (cmd_idx),
      .chain_found_i (ch_found[g]),
      .chain_key_i   (ch_key[g]),
      .chain_port_i  (ch_port[g]),
      .chain_rank_i  (ch_rank[g]),
      .chain_idx_i   (ch_idx[g]),
      .chain_found_o (ch_found[g+1]),
      .chain_key_o   (ch_key[g+1]),
      .chain_port_o  (ch_port[g+1]),
      .chain_rank_o  (ch_rank[g+1]),
      .chain_idx_o   (ch_idx[g+1])
    );
  end

  logic          hit_end;
  logic [PW-1:0] port_end;
  logic [RW-1:0] rank_end;
  assign hit_end  = ch_found[N];
  assign port_end = ch_port[N];
  assign rank_end = ch_rank[N];

  // session limit: 0 or anything above the table size means the table size
  logic [31:0] limit;
  logic        at_limit;
  assign limit    = (max_q == 7'd0 || 32'(max_q) > 32'(N)) ? 32'(N) : 32'(max_q);
  assign at_limit = (32'(live_q) >= limit) && (live_q != '0);

  logic [RW-1:0] lru_rank;
  assign lru_rank = RW'(live_q - 1'b1);

  always_comb begin
    state_d      = state_q;
    ret_d        = ret_q;
    cnt_d        = cnt_q;
    live_d       = live_q;
    ctr_d        = ctr_q;
    cand_d       = cand_q;
    op_d         = op_q;
    key_d        = key_q;
    ev_valid_d   = ev_valid_q;
    ev_port_d    = ev_port_q;
    res_v_d      = 1'b0;
    res_found_d  = 1'b0;
    res_mport_d  = '0;
    res_ev_d     = 1'b0;
    res_evport_d = '0;
    res_key_d    = '0;
    cmd.op       = nst_pkg::CMD_NOP;
    cmd.key      = key_q;
    cmd.port     = cand_q;
    cmd_rank     = '0;
    cmd_idx      = ch_idx[N];

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d       = opcode_i;
          key_d      = {src_ip_i, src_port_i, dst_ip_i, dst_port_i};
          ev_valid_d = 1'b0;
          ev_port_d  = '0;
          cnt_d      = LW'(N);
          priority if (opcode_i == nst_pkg::OP_LOOKUP) begin
            cmd.op  = nst_pkg::CMD_MATCH_KEY;
            cmd.key = {src_ip_i, src_port_i, dst_ip_i, dst_port_i};
            ret_d   = S_KEY_DONE;
            state_d = S_WAIT;
          end else if (opcode_i == nst_pkg::OP_ERASE ||
                       opcode_i == nst_pkg::OP_REVERSE) begin
            cmd.op   = nst_pkg::CMD_MATCH_PORT;
            cmd.port = query_port_i;
            ret_d    = S_PORT_DONE;
            state_d  = S_WAIT;
          end else begin
            res_v_d = 1'b1;  // unknown opcode: all-zero result
          end
        end
      end

      S_WAIT: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == LW'(1)) begin
          state_d = ret_q;
        end
      end

      S_KEY_DONE: begin
        if (hit_end) begin
          cmd.op      = nst_pkg::CMD_PROMOTE;
          cmd_rank    = rank_end;
          res_v_d     = 1'b1;
          res_found_d = 1'b1;
          res_mport_d = port_end;
          state_d     = S_IDLE;
        end else if (at_limit) begin
          cmd.op   = nst_pkg::CMD_MATCH_RANK;
          cmd_rank = lru_rank;
          cnt_d    = LW'(N);
          ret_d    = S_EVICT_DONE;
          state_d  = S_WAIT;
        end else begin
          state_d = S_PROBE;
        end
      end

      S_EVICT_DONE: begin
        // hit flags still mark the LRU slot
        cmd.op     = nst_pkg::CMD_REMOVE;
        cmd_rank   = lru_rank;
        ev_valid_d = 1'b1;
        ev_port_d  = port_end;
        live_d     = live_q - 1'b1;
        state_d    = S_PROBE;
      end

      S_PROBE: begin
        if (ctr_q == '0) begin
          ctr_d = nst_pkg::PORT_BASE;
        end else begin
          ctr_d    = ctr_q + 1'b1;
          cand_d   = ctr_q;
          cmd.op   = nst_pkg::CMD_MATCH_PORT;
          cmd.port = ctr_q;
          cnt_d    = LW'(N);
          ret_d    = S_PROBE_DONE;
          state_d  = S_WAIT;
        end
      end

      S_PROBE_DONE: begin
        if (hit_end) begin
          state_d = S_PROBE;  // port in use, try the next one
        end else begin
          cmd.op  = nst_pkg::CMD_MATCH_FREE;
          cnt_d   = LW'(N);
          ret_d   = S_FREE_DONE;
          state_d = S_WAIT;
        end
      end

      S_FREE_DONE: begin
        cmd.op       = nst_pkg::CMD_INSERT;
        cmd_idx      = ch_idx[N];
        live_d       = live_q + 1'b1;
        res_v_d      = 1'b1;
        res_mport_d  = cand_q;
        res_ev_d     = ev_valid_q;
        res_evport_d = ev_port_q;
        state_d      = S_IDLE;
      end

      S_PORT_DONE: begin
        res_v_d     = 1'b1;
        res_found_d = hit_end;
        if (op_q == nst_pkg::OP_ERASE) begin
          if (hit_end) begin
            cmd.op   = nst_pkg::CMD_REMOVE;
            cmd_rank = rank_end;
            live_d   = live_q - 1'b1;
          end
        end else if (hit_end) begin
          res_key_d = ch_key[N];
        end
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign busy = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      ret_q          <= S_IDLE;
      cnt_q          <= '0;
      live_q         <= '0;
      ctr_q          <= nst_pkg::PORT_BASE;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      ret_q          <= ret_d;
      cnt_q          <= cnt_d;
      live_q         <= live_d;
      ctr_q          <= ctr_d;
      result_valid_o <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q     <= cand_d;
    op_q       <= op_d;
    key_q      <= key_d;
    ev_valid_q <= ev_valid_d;
    ev_port_q  <= ev_port_d;
    if (res_v_d) begin
      found_o         <= res_found_d;
      mapped_port_o   <= res_mport_d;
      evicted_valid_o <= res_ev_d;
      evicted_port_o  <= res_evport_d;
      flow_src_ip_o   <= res_key_d[95:64];
      flow_src_port_o <= res_key_d[63:48];
      flow_dst_ip_o   <= res_key_d[47:16];
      flow_dst_port_o <= res_key_d[15:0];
    end
  end

endmodule
